// File: design/uart_8n1_transceiver_defines.svh
// Assertion macros shared by the checker of the serial transceiver.
`ifndef UART_8N1_TRANSCEIVER_DEFINES_SVH
`define UART_8N1_TRANSCEIVER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define U8N1_ASSERT_NOW(label, clk, off, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (off) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define U8N1_ASSERT_NEXT(label, clk, off, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (off) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/u8n1_pkg.sv
// Types and constants of the 8N1 serial transceiver.
package u8n1_pkg;

   localparam int unsigned CFG_W     = 16;
   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned CNT_W     = 4;
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned IDX_W     = 2;

   localparam logic [CMD_W-1:0] CMD_IDLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RECV = 2'd2;

   localparam logic [IDX_W-1:0] REG_BIT_PERIOD  = 2'd0;
   localparam logic [IDX_W-1:0] REG_HALF_PERIOD = 2'd1;
   localparam logic [IDX_W-1:0] REG_TIMEOUT     = 2'd2;

   localparam logic [CFG_W-1:0] BIT_PERIOD_RST  = 16'd104;
   localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd52;
   localparam logic [CFG_W-1:0] TIMEOUT_RST     = 16'd65535;

   typedef enum logic [3:0] {
      TX_IDLE  = 4'b0001,
      TX_START = 4'b0010,
      TX_DATA  = 4'b0100,
      TX_STOP  = 4'b1000
   } tx_phase_type;

   typedef enum logic [4:0] {
      RX_IDLE       = 5'b00001,
      RX_WAIT_START = 5'b00010,
      RX_HALF       = 5'b00100,
      RX_BITS       = 5'b01000,
      RX_WAIT_STOP  = 5'b10000
   } rx_phase_type;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [BYTE_BITS-1:0] tx_byte;
      logic                 rx_line;
   } req_type;

   typedef struct packed {
      logic                 tx_line;
      logic                 tx_busy;
      logic                 rx_busy;
      logic                 rx_valid;
      logic                 rx_timeout;
      logic [BYTE_BITS-1:0] rx_byte;
   } rsp_type;

endpackage

// File: design/uart_8n1_transceiver.sv
// Top level of the 8N1 serial transmitter and receiver, one beat per clock tick.
//
// Each req beat is one tick of the oversampled serial line: a command (idle,
// send tx_byte, start a receive), the byte to send and the sampled rx line.
// Each req beat yields exactly one rsp beat with the transmit line level, the
// busy flags of both sides and, on the tick a receive ends, the byte with
// rx_valid or the rx_timeout flag. Transmit and receive run independently.
// The csr channel writes bit_period (0), half_period (1) and timeout_ticks (2);
// it is always ready; the user must write it only while no beat is in flight,
// which the block does not enforce. Each rsp beat leaves from a register.
// Throughput: one beat per cycle while req_stall is low; the next state is
// computed from the registered side state and the req beat in one pass.
// When rsp is stalled, one result sits in the output register and one more
// in a skid register; req_stall rises only when the skid register is full.
// Reset (synchronous) restores bit_period 104, half_period 52 and
// timeout_ticks 65535, puts both sides idle and empties the output stage.
module uart_8n1_transceiver
   import u8n1_pkg::*;
#(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int unsigned EW = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;
   localparam logic [EW-1:0] TOP = EW'(1) << TIMER_BITS;
   localparam logic [TIMER_BITS:0] ONE = (TIMER_BITS + 1)'(1);

   logic [CFG_W-1:0] bit_period_ff, half_period_ff, timeout_ff;

   tx_phase_type            tx_phase_ff, tx_phase_in;
   logic [BYTE_BITS-1:0]    tx_shift_ff, tx_shift_in;
   logic [CNT_W-1:0]        tx_cnt_ff, tx_cnt_in;
   logic [TIMER_BITS-1:0]   tx_timer_ff, tx_timer_in;

   rx_phase_type            rx_phase_ff, rx_phase_in;
   logic [BYTE_BITS-1:0]    rx_shift_ff, rx_shift_in;
   logic [CNT_W-1:0]        rx_cnt_ff, rx_cnt_in;
   logic [TIMER_BITS-1:0]   rx_timer_ff, rx_timer_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic                    skid_valid_ff, skid_valid_in;
   rsp_type                 skid_data_ff, skid_data_in;

   logic [TIMER_BITS:0]     per_c, half_c, lim_c;
   logic [TIMER_BITS:0]     tx_t, rx_t;
   logic                    req_accept, out_take;
   logic                    rx_ok, rx_to;
   rsp_type                 result;

   function automatic logic [TIMER_BITS:0] clamp_top(input logic [CFG_W-1:0] v);
      logic [EW-1:0] ext;
      begin
         ext = EW'(v);
         if (ext > TOP) begin
            clamp_top = TOP[TIMER_BITS:0];
         end else begin
            clamp_top = ext[TIMER_BITS:0];
         end
      end
   endfunction

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_take   = rsp_valid_ff && !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      per_c  = (bit_period_ff == '0) ? ONE : clamp_top(bit_period_ff);
      half_c = clamp_top(half_period_ff);
      lim_c  = (timeout_ff == '0) ? ONE : clamp_top(timeout_ff);
   end

   // transmit side
   always_comb begin
      tx_phase_in = tx_phase_ff;
      tx_shift_in = tx_shift_ff;
      tx_cnt_in   = tx_cnt_ff;
      tx_timer_in = tx_timer_ff;
      tx_t        = {1'b0, tx_timer_ff} + ONE;
      if (req_accept) begin
         if (tx_phase_ff == TX_IDLE) begin
            if (req_data.command == CMD_SEND) begin
               tx_shift_in = req_data.tx_byte;
               tx_cnt_in   = '0;
               tx_timer_in = '0;
               tx_phase_in = TX_START;
            end
         end else if (tx_t < per_c) begin
            tx_timer_in = tx_t[TIMER_BITS-1:0];
         end else begin
            tx_timer_in = '0;
            case (tx_phase_ff)
               TX_START: begin
                  tx_phase_in = TX_DATA;
                  tx_cnt_in   = '0;
               end
               TX_DATA: begin
                  tx_shift_in = tx_shift_ff >> 1;
                  tx_cnt_in   = tx_cnt_ff + CNT_W'(1);
                  if (tx_cnt_in[CNT_W-1]) begin
                     tx_phase_in = TX_STOP;
                  end
               end
               default: begin
                  tx_phase_in = TX_IDLE;
               end
            endcase
         end
      end
   end

   // receive side
   always_comb begin
      rx_phase_in = rx_phase_ff;
      rx_shift_in = rx_shift_ff;
      rx_cnt_in   = rx_cnt_ff;
      rx_timer_in = rx_timer_ff;
      rx_ok       = 1'b0;
      rx_to       = 1'b0;
      rx_t        = '0;
      if (req_accept) begin
         if (rx_phase_ff != RX_WAIT_START && rx_phase_ff != RX_HALF &&
             rx_phase_ff != RX_BITS && rx_phase_ff != RX_WAIT_STOP) begin
            rx_phase_in = RX_IDLE;
         end
         if (rx_phase_in == RX_IDLE && req_data.command == CMD_RECV) begin
            rx_shift_in = '0;
            rx_cnt_in   = '0;
            rx_timer_in = '0;
            rx_phase_in = RX_WAIT_START;
         end
         rx_t = {1'b0, rx_timer_in} + ONE;
         case (rx_phase_in)
            RX_WAIT_START: begin
               if (!req_data.rx_line) begin
                  rx_timer_in = '0;
                  rx_phase_in = (half_c == '0) ? RX_BITS : RX_HALF;
               end else if (rx_t >= lim_c) begin
                  rx_to       = 1'b1;
                  rx_phase_in = RX_IDLE;
                  rx_timer_in = '0;
               end else begin
                  rx_timer_in = rx_t[TIMER_BITS-1:0];
               end
            end
            RX_HALF: begin
               if (rx_t >= half_c) begin
                  rx_timer_in = '0;
                  rx_phase_in = RX_BITS;
               end else begin
                  rx_timer_in = rx_t[TIMER_BITS-1:0];
               end
            end
            RX_BITS: begin
               if (rx_t < per_c) begin
                  rx_timer_in = rx_t[TIMER_BITS-1:0];
               end else begin
                  rx_timer_in = '0;
                  rx_shift_in[rx_cnt_in[2:0]] = rx_shift_in[rx_cnt_in[2:0]] | req_data.rx_line;
                  rx_cnt_in = rx_cnt_in + CNT_W'(1);
                  if (rx_cnt_in[CNT_W-1]) begin
                     rx_phase_in = RX_WAIT_STOP;
                  end
               end
            end
            RX_WAIT_STOP: begin
               if (req_data.rx_line) begin
                  rx_ok       = 1'b1;
                  rx_phase_in = RX_IDLE;
                  rx_timer_in = '0;
               end else if (rx_t >= lim_c) begin
                  rx_to       = 1'b1;
                  rx_phase_in = RX_IDLE;
                  rx_timer_in = '0;
               end else begin
                  rx_timer_in = rx_t[TIMER_BITS-1:0];
               end
            end
            default: begin
               rx_phase_in = RX_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      case (tx_phase_in)
         TX_START: result.tx_line = 1'b0;
         TX_DATA:  result.tx_line = tx_shift_in[0];
         default:  result.tx_line = 1'b1;
      endcase
      result.tx_busy    = (tx_phase_in != TX_IDLE);
      result.rx_busy    = (rx_phase_in != RX_IDLE);
      result.rx_valid   = rx_ok;
      result.rx_timeout = rx_to;
      result.rx_byte    = rx_ok ? rx_shift_in : '0;
   end

   // output register with one skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         if (rsp_valid_ff && !out_take) begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end else begin
            rsp_data_in  = result;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff  <= BIT_PERIOD_RST;
         half_period_ff <= HALF_PERIOD_RST;
         timeout_ff     <= TIMEOUT_RST;
         tx_phase_ff    <= TX_IDLE;
         tx_shift_ff    <= '0;
         tx_cnt_ff      <= '0;
         tx_timer_ff    <= '0;
         rx_phase_ff    <= RX_IDLE;
         rx_shift_ff    <= '0;
         rx_cnt_ff      <= '0;
         rx_timer_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BIT_PERIOD:  bit_period_ff  <= csr_data;
               REG_HALF_PERIOD: half_period_ff <= csr_data;
               REG_TIMEOUT:     timeout_ff     <= csr_data;
               default: ;
            endcase
         end
         tx_phase_ff   <= tx_phase_in;
         tx_shift_ff   <= tx_shift_in;
         tx_cnt_ff     <= tx_cnt_in;
         tx_timer_ff   <= tx_timer_in;
         rx_phase_ff   <= rx_phase_in;
         rx_shift_ff   <= rx_shift_in;
         rx_cnt_ff     <= rx_cnt_in;
         rx_timer_ff   <= rx_timer_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// File: design/u8n1_checker.sv
// Port-level checks of the serial transceiver, bound to its top level.
`include "uart_8n1_transceiver_defines.svh"

module u8n1_checker
   import u8n1_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `U8N1_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled rsp beat changed")
   `U8N1_ASSERT_NOW(a_rx_end_one_kind, clock, reset, rsp_valid && (rsp_data.rx_valid || rsp_data.rx_timeout), !(rsp_data.rx_valid && rsp_data.rx_timeout) && !rsp_data.rx_busy, "receive ended both ways or stayed busy")
   `U8N1_ASSERT_NOW(a_rx_byte_zero, clock, reset, rsp_valid && !rsp_data.rx_valid, rsp_data.rx_byte == '0, "rx_byte set without rx_valid")
   `U8N1_ASSERT_NOW(a_tx_idle_high, clock, reset, rsp_valid && !rsp_data.tx_busy, rsp_data.tx_line, "idle transmit line not high")
   `U8N1_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp beat right after reset")

endmodule

bind uart_8n1_transceiver u8n1_checker u_u8n1_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
